/* hw/rtl/rmlt_pkg.sv */
// rmlt_pkg: shared codes and beat types of the reentrant monitor lock table
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package rmlt_pkg;

    // fixed field widths
    localparam int CMD_W    = 3;
    localparam int HANDLE_W = 6;
    localparam int PID_W    = 32;
    localparam int WAITER_W = 64;
    localparam int STATUS_W = 3;
    localparam int DEPTH_W  = 16;

    // operation codes; the first five match the command codes on the port
    localparam logic [CMD_W-1:0] OP_ACQUIRE  = 3'd0;
    localparam logic [CMD_W-1:0] OP_RELEASE  = 3'd1;
    localparam logic [CMD_W-1:0] OP_ADD      = 3'd2;
    localparam logic [CMD_W-1:0] OP_POP      = 3'd3;
    localparam logic [CMD_W-1:0] OP_POP_ALL  = 3'd4;
    // classes made by the front end
    localparam logic [CMD_W-1:0] OP_INVALID  = 3'd5;
    localparam logic [CMD_W-1:0] OP_IGNORE   = 3'd6;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HELD      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_OWNER = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DEPTH     = 3'd5;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 16'hFFFF;

    // command beat
    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [HANDLE_W-1:0] handle;
        logic                object_valid;
        logic [PID_W-1:0]    requester_pid;
        logic [WAITER_W-1:0] waiter_in;
    } cmd_t;

    // result beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WAITER_W-1:0] woken_pid;
        logic                last;
    } result_t;

    // classified item held in the queue between front and back
    typedef struct packed {
        logic [CMD_W-1:0]    op;
        logic [HANDLE_W-1:0] handle;
        logic [PID_W-1:0]    requester_pid;
        logic [WAITER_W-1:0] waiter_in;
    } item_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_out_t;

    // back end feedback to the front end
    typedef struct packed {
        logic take;
        logic init_busy;
    } back_status_t;

endpackage

/* hw/rtl/rmlt_front.sv */
// rmlt_front: command intake, classification and two-entry item queue
// depends on rmlt_pkg
`timescale 1ns / 1ps

module rmlt_front #(
    parameter int NUM_HANDLES = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  rmlt_pkg::cmd_t        cmd,
    output rmlt_pkg::queue_out_t  q_out,
    input  rmlt_pkg::back_status_t back_stat
);
    import rmlt_pkg::*;

    localparam logic [1:0] Q_FULL = 2'd2;

    item_t      slots_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    item_t      item_in;
    logic       push;
    logic       pop;
    logic       in_range;

    // handshake
    assign busy = (cnt_reg == Q_FULL) || back_stat.init_busy;
    assign push = start && !busy;
    assign pop  = back_stat.take;

    // classify the beat
    assign in_range = 32'(cmd.handle) < 32'(NUM_HANDLES);

    always_comb
    begin
        item_in.op            = cmd.command;
        item_in.handle        = cmd.handle;
        item_in.requester_pid = cmd.requester_pid;
        item_in.waiter_in     = cmd.waiter_in;
        if (cmd.command > OP_POP_ALL)
        begin
            item_in.op     = OP_IGNORE;
            item_in.handle = '0;
        end
        else if (!in_range)
        begin
            item_in.op     = OP_INVALID;
            item_in.handle = '0;
        end
        else if ((cmd.command == OP_ACQUIRE || cmd.command == OP_RELEASE)
                 && !cmd.object_valid)
        begin
            item_in.op = OP_INVALID;
        end
    end

    // queue occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_reg] <= item_in;
        end
    end

    assign q_out.valid = (cnt_reg != 2'd0);
    assign q_out.item  = slots_reg[rd_reg];

endmodule

/* hw/rtl/rmlt_back.sv */
// rmlt_back: executes items against the monitor table and the wait store
// depends on rmlt_pkg; holds both memories of the block
`timescale 1ns / 1ps

module rmlt_back #(
    parameter int NUM_HANDLES = 64,
    parameter int WAIT_DEPTH  = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rmlt_pkg::queue_out_t   q_out,
    output rmlt_pkg::back_status_t back_stat,
    output logic                   result_strobe,
    output rmlt_pkg::result_t      result
);
    import rmlt_pkg::*;

    localparam int HW = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;
    localparam int QW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CW = $clog2(WAIT_DEPTH + 1);
    localparam int NSLOT = NUM_HANDLES * WAIT_DEPTH;
    localparam int SW = $clog2(NSLOT);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    typedef struct packed {
        logic [PID_W-1:0]   owner;
        logic [DEPTH_W-1:0] depth;
        logic [QW-1:0]      head;
        logic [CW-1:0]      count;
    } mon_t;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [HW-1:0] clr_reg;
    logic [HW-1:0] clr_next;
    item_t         cur_reg;
    item_t         cur_next;
    mon_t          wk_reg;
    mon_t          wk_next;
    result_t       res_reg;
    result_t       res_next;
    logic          strobe_reg;
    logic          strobe_next;

    mon_t          mon_mem [NUM_HANDLES];
    mon_t          mon_rd_reg;
    logic          mon_re;
    logic [HW-1:0] mon_ra;
    logic          mon_we;
    logic [HW-1:0] mon_wa;
    mon_t          mon_wd;

    logic [WAITER_W-1:0] wait_mem [NSLOT];
    logic [WAITER_W-1:0] wait_rd_reg;
    logic                wait_re;
    logic [SW-1:0]       wait_ra;
    logic                wait_we;
    logic [SW-1:0]       wait_wa;

    mon_t          mon_mod;
    logic [HW-1:0] hx;
    logic [CW:0]   tail_sum;
    logic [QW-1:0] tail_slot;
    logic          more;

    function automatic logic [QW-1:0] next_slot(input logic [QW-1:0] s);
        return (s == QW'(WAIT_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [SW-1:0] slot_addr(input logic [HW-1:0] h,
                                                input logic [QW-1:0] s);
        return SW'(h) * SW'(WAIT_DEPTH) + SW'(s);
    endfunction

    assign hx = HW'(cur_reg.handle);

    // tail slot of the queue, wrapped once
    always_comb
    begin
        tail_sum = (CW + 1)'(mon_rd_reg.head) + (CW + 1)'(mon_rd_reg.count);
        if (tail_sum >= (CW + 1)'(WAIT_DEPTH))
        begin
            tail_sum = tail_sum - (CW + 1)'(WAIT_DEPTH);
        end
        tail_slot = QW'(tail_sum);
    end

    assign more = (cur_reg.op == OP_POP_ALL) && (wk_reg.count != '0);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        cur_next    = cur_reg;
        wk_next     = wk_reg;
        res_next    = res_reg;
        strobe_next = 1'b0;
        mon_re      = 1'b0;
        mon_ra      = HW'(q_out.item.handle);
        mon_we      = 1'b0;
        mon_wa      = hx;
        mon_wd      = mon_rd_reg;
        wait_re     = 1'b0;
        wait_ra     = slot_addr(hx, mon_rd_reg.head);
        wait_we     = 1'b0;
        wait_wa     = slot_addr(hx, tail_slot);
        mon_mod     = mon_rd_reg;
        back_stat.take      = 1'b0;
        back_stat.init_busy = (state_reg == S_CLEAR);

        unique case (state_reg)
            S_CLEAR:
            begin
                mon_we   = 1'b1;
                mon_wa   = clr_reg;
                mon_wd   = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == HW'(NUM_HANDLES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (q_out.valid)
                begin
                    back_stat.take = 1'b1;
                    mon_re         = 1'b1;
                    cur_next       = q_out.item;
                    state_next     = S_EXEC;
                end
            end

            S_EXEC:
            begin
                strobe_next = 1'b1;
                res_next    = '{status: ST_DONE, woken_pid: '0, last: 1'b1};
                state_next  = S_IDLE;
                unique case (cur_reg.op) inside
                    OP_ACQUIRE:
                    begin
                        if (mon_rd_reg.owner == '0)
                        begin
                            mon_mod.owner = cur_reg.requester_pid;
                            mon_mod.depth = DEPTH_W'(1);
                            mon_we        = 1'b1;
                        end
                        else if (mon_rd_reg.owner == cur_reg.requester_pid)
                        begin
                            if (mon_rd_reg.depth == DEPTH_MAX)
                            begin
                                res_next.status = ST_DEPTH;
                            end
                            else
                            begin
                                mon_mod.depth = mon_rd_reg.depth + 1'b1;
                                mon_we        = 1'b1;
                            end
                        end
                        else
                        begin
                            res_next.status = ST_HELD;
                        end
                    end

                    OP_RELEASE:
                    begin
                        if (mon_rd_reg.owner != cur_reg.requester_pid)
                        begin
                            res_next.status = ST_NOT_OWNER;
                        end
                        else if (mon_rd_reg.depth > DEPTH_W'(1))
                        begin
                            mon_mod.depth = mon_rd_reg.depth - 1'b1;
                            mon_we        = 1'b1;
                        end
                        else
                        begin
                            mon_mod.owner = '0;
                            mon_mod.depth = '0;
                            if (mon_rd_reg.count != '0)
                            begin
                                // free the monitor now, report the oldest waiter in the emit state
                                strobe_next   = 1'b0;
                                wait_re       = 1'b1;
                                wk_next       = mon_mod;
                                wk_next.head  = next_slot(mon_rd_reg.head);
                                wk_next.count = mon_rd_reg.count - 1'b1;
                                state_next    = S_EMIT;
                            end
                            else
                            begin
                                mon_we = 1'b1;
                            end
                        end
                    end

                    OP_ADD:
                    begin
                        if (mon_rd_reg.count == CW'(WAIT_DEPTH))
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            wait_we       = 1'b1;
                            mon_mod.count = mon_rd_reg.count + 1'b1;
                            mon_we        = 1'b1;
                        end
                    end

                    OP_POP, OP_POP_ALL:
                    begin
                        if (mon_rd_reg.count != '0)
                        begin
                            strobe_next   = 1'b0;
                            wait_re       = 1'b1;
                            wk_next       = mon_rd_reg;
                            wk_next.head  = next_slot(mon_rd_reg.head);
                            wk_next.count = mon_rd_reg.count - 1'b1;
                            state_next    = S_EMIT;
                        end
                    end

                    OP_INVALID:
                    begin
                        res_next.status = ST_INVALID;
                    end

                    default:
                    begin
                        res_next.status = ST_DONE;
                    end
                endcase
                mon_wd = mon_mod;
            end

            S_EMIT:
            begin
                // one popped waiter per cycle, next read overlaps this beat
                strobe_next = 1'b1;
                res_next    = '{status: ST_DONE, woken_pid: wait_rd_reg, last: !more};
                if (more)
                begin
                    wait_re       = 1'b1;
                    wait_ra       = slot_addr(hx, wk_reg.head);
                    wk_next.head  = next_slot(wk_reg.head);
                    wk_next.count = wk_reg.count - 1'b1;
                end
                else
                begin
                    mon_we     = 1'b1;
                    mon_wd     = wk_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            strobe_reg <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        wk_reg  <= wk_next;
        res_reg <= res_next;
    end

    // monitor table
    always_ff @(posedge clk)
    begin
        if (mon_we)
        begin
            mon_mem[mon_wa] <= mon_wd;
        end
        if (mon_re)
        begin
            mon_rd_reg <= mon_mem[mon_ra];
        end
    end

    // wait store
    always_ff @(posedge clk)
    begin
        if (wait_we)
        begin
            wait_mem[wait_wa] <= cur_reg.waiter_in;
        end
        if (wait_re)
        begin
            wait_rd_reg <= wait_mem[wait_ra];
        end
    end

    assign result_strobe = strobe_reg;
    assign result        = res_reg;

endmodule

/* hw/rtl/reentrant_monitor_lock_table.sv */
// reentrant_monitor_lock_table: top level of the monitor lock table
// depends on rmlt_pkg, rmlt_front and rmlt_back
//
// usage
// - command channel: a beat on cmd is taken at a rising edge with start high
//   and busy low; cmd carries command, handle, object_valid, requester_pid
//   and waiter_in
// - result channel: each result beat is on result for one cycle with
//   result_strobe high; the receiver takes it then and cannot stall it
// - every command yields one result beat with last set, except pop all,
//   which yields one beat per queued waiter, the final one with last set
// - a command passes the queue, the monitor table read and the result
//   register before its first result shows; each command is one monitor
//   table read-modify-write, done before the next is taken; pop one and
//   release with a waiter add an emit step; pop all adds a wait store read per waiter
// - a two-entry queue sits between intake and execution, so busy rises
//   when that queue holds two commands or while the table is cleared
// - after reset the monitor table is cleared, one entry per cycle, with
//   busy high; the wait store is not cleared
`timescale 1ns / 1ps

module reentrant_monitor_lock_table #(
    parameter int NUM_HANDLES = 64,
    parameter int WAIT_DEPTH  = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rmlt_pkg::cmd_t    cmd,
    output logic              result_strobe,
    output rmlt_pkg::result_t result
);
    import rmlt_pkg::*;

    queue_out_t   q_out;
    back_status_t back_stat;

    // intake and classification
    rmlt_front #(
        .NUM_HANDLES (NUM_HANDLES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .q_out     (q_out),
        .back_stat (back_stat)
    );

    // execution against the monitor table and wait store
    rmlt_back #(
        .NUM_HANDLES (NUM_HANDLES),
        .WAIT_DEPTH  (WAIT_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_out         (q_out),
        .back_stat     (back_stat),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

/* hw/rtl/rmlt_checker.sv */
// rmlt_props: port-level checks on the result stream of the lock table
// depends on rmlt_pkg; bound to reentrant_monitor_lock_table
`timescale 1ns / 1ps

module rmlt_props (
    input logic              clk,
    input logic              rst_n,
    input logic              busy,
    input logic              result_strobe,
    input rmlt_pkg::result_t result
);
    import rmlt_pkg::*;

    // a beat that is not last belongs to a pop all stream
    a_mid_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.last |-> result.status == ST_DONE)
        else $error("non-final result beat without done status");

    // a pop all stream delivers one waiter per cycle without gaps
    a_stream: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.last |=> result_strobe)
        else $error("gap inside a pop all result stream");

    // a refused command never hands out a waiter
    a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.status != ST_DONE |-> result.woken_pid == '0)
        else $error("refused command reported a woken pid");

    // busy is high when reset is released, so no command is taken as the table clear starts
    a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> busy)
        else $error("busy low during monitor table clear");

endmodule

bind reentrant_monitor_lock_table rmlt_props u_rmlt_props (.*);
